### design/tbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and constants of the bounding box block
// Holds field widths, register indexes and reset values, the queue entry
// type and the frame dimension clamp.
// ----------------------------------------------------------------------------
package tbb_pkg;

   localparam int MAX_DIM      = 4096;
   localparam int PIXEL_BITS   = 16;
   localparam int POS_BITS     = 12;
   localparam int DIM_BITS     = 13;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESHOLD    = 2'd2;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET     = 13'd1920;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET    = 13'd1080;
   localparam logic [PIXEL_BITS-1:0] THRESHOLD_RESET = 16'd0;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int QUEUE_CNT_BITS  = 2;

   typedef struct packed {
      logic [DIM_BITS-1:0]   frame_width;
      logic [DIM_BITS-1:0]   frame_height;
      logic [PIXEL_BITS-1:0] threshold;
   } tbb_cfg_type;

   typedef struct packed {
      logic                hit;
      logic                last;
      logic [POS_BITS-1:0] col;
      logic [POS_BITS-1:0] row;
   } tbb_item_type;

   // Clamp a programmed dimension to 1..MAX_DIM.
   function automatic logic [DIM_BITS-1:0] dim_in_use(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### design/tbb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_front: pixel intake and classification
// Tracks the raster position, tests each pixel against the threshold and
// hands a tagged item to the queue.
// ----------------------------------------------------------------------------
module tbb_front import tbb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  tbb_cfg_type           cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   input  logic                  queue_full,
   output logic                  push,
   output tbb_item_type          push_item
);

   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0] width_use;
   logic [DIM_BITS-1:0] height_use;
   logic                line_end;
   logic                frame_end;

   assign req_ready  = !queue_full;
   assign push       = req_valid && !queue_full;
   assign width_use  = dim_in_use(cfg.frame_width);
   assign height_use = dim_in_use(cfg.frame_height);
   assign line_end   = ({1'b0, col_ff} + DIM_BITS'(1)) >= width_use;
   assign frame_end  = line_end && (({1'b0, row_ff} + DIM_BITS'(1)) >= height_use);

   always_comb begin
      push_item.hit  = req_pixel > cfg.threshold;
      push_item.last = frame_end;
      push_item.col  = col_ff;
      push_item.row  = row_ff;
   end

   // Advance the raster position; wrap at line end, restart at frame end.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (line_end) begin
            col_in = '0;
            row_in = row_ff + POS_BITS'(1);
         end else begin
            col_in = col_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### design/tbb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_queue: short item queue
// Small register queue that decouples pixel intake from bound tracking.
// ----------------------------------------------------------------------------
module tbb_queue import tbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tbb_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output tbb_item_type head_item
);

   tbb_item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/tbb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbb_back: bound tracking and result register
// Folds classified pixels into running min/max bounds and registers the
// frame result on the last pixel.
// ----------------------------------------------------------------------------
module tbb_back import tbb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  tbb_item_type        item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [POS_BITS-1:0] rsp_left_col,
   output logic [POS_BITS-1:0] rsp_top_row,
   output logic [POS_BITS-1:0] rsp_right_col,
   output logic [POS_BITS-1:0] rsp_bottom_row
);

   logic                any_ff, any_in;
   logic [POS_BITS-1:0] min_col_ff, min_col_in;
   logic [POS_BITS-1:0] max_col_ff, max_col_in;
   logic [POS_BITS-1:0] min_row_ff, min_row_in;
   logic [POS_BITS-1:0] max_row_ff, max_row_in;
   logic                out_valid_ff;
   logic                found_ff;
   logic [POS_BITS-1:0] left_ff, top_ff, right_ff, bottom_ff;

   // Hold a last pixel while the previous result is still unclaimed.
   assign pop = item_valid && (!item.last || !out_valid_ff || rsp_ready);

   always_comb begin
      any_in     = any_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      if (item.hit) begin
         any_in = 1'b1;
         if (!any_ff) begin
            min_col_in = item.col;
            max_col_in = item.col;
            min_row_in = item.row;
            max_row_in = item.row;
         end else begin
            if (item.col < min_col_ff) min_col_in = item.col;
            if (item.col > max_col_ff) max_col_in = item.col;
            if (item.row < min_row_ff) min_row_in = item.row;
            if (item.row > max_row_ff) max_row_in = item.row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff     <= 1'b0;
         min_col_ff <= '0;
         max_col_ff <= '0;
         min_row_ff <= '0;
         max_row_ff <= '0;
      end else if (pop) begin
         if (item.last) begin
            any_ff     <= 1'b0;
            min_col_ff <= '0;
            max_col_ff <= '0;
            min_row_ff <= '0;
            max_row_ff <= '0;
         end else begin
            any_ff     <= any_in;
            min_col_ff <= min_col_in;
            max_col_ff <= max_col_in;
            min_row_ff <= min_row_in;
            max_row_ff <= max_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop && item.last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && item.last) begin
         found_ff  <= any_in;
         left_ff   <= any_in ? min_col_in : '0;
         top_ff    <= any_in ? min_row_in : '0;
         right_ff  <= any_in ? max_col_in : '0;
         bottom_ff <= any_in ? max_row_in : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_left_col   = left_ff;
   assign rsp_top_row    = top_ff;
   assign rsp_right_col  = right_ff;
   assign rsp_bottom_row = bottom_ff;

endmodule

### design/threshold_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_bounding_box: bounding box of above-threshold pixels
// Streams one frame of pixels in raster order and reports the bounds of the
// pixels that exceed a programmable threshold.
// ----------------------------------------------------------------------------
// Feed pixels in raster order on the req_ channel; each request is one pixel
// and the block takes one per clock while the queue has room. Position
// counters run against frame_width and frame_height (0 acts as 1, values
// above 4096 as 4096). A pixel counts when it is strictly greater than
// threshold. On the last pixel of a frame one response appears on the rsp_
// channel: found, plus the inclusive left/top/right/bottom bounds of the
// counting pixels, all bounds 0 when nothing counted. The block then starts
// a fresh frame. Each pixel passes the intake stage (counter update and
// threshold compare) and then the bound tracker; a two-entry queue sits
// between them and the response sits in an output register, so intake only
// stalls when a frame result is still waiting to be taken and the queue has
// filled. Program the csr_ registers (0 width, 1 height, 2 threshold) only
// while idle; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module threshold_bounding_box import tbb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIXEL_BITS-1:0]   req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [POS_BITS-1:0]     rsp_left_col,
   output logic [POS_BITS-1:0]     rsp_top_row,
   output logic [POS_BITS-1:0]     rsp_right_col,
   output logic [POS_BITS-1:0]     rsp_bottom_row
);

   tbb_cfg_type  cfg_ff;
   logic         push;
   tbb_item_type push_item;
   logic         queue_full;
   logic         pop;
   logic         queue_not_empty;
   tbb_item_type head_item;

   // Register writes are always accepted; csr_ready is tied high.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
         cfg_ff.threshold    <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= csr_data[DIM_BITS-1:0];
            REG_THRESHOLD:    cfg_ff.threshold    <= csr_data[PIXEL_BITS-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   // Intake: position tracking and threshold test.
   tbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Decouple intake from bound tracking.
   tbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   // Bound tracking and frame result.
   tbb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (queue_not_empty),
      .item           (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_left_col   (rsp_left_col),
      .rsp_top_row    (rsp_top_row),
      .rsp_right_col  (rsp_right_col),
      .rsp_bottom_row (rsp_bottom_row)
   );

endmodule

### tb/threshold_bounding_box_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_bounding_box_tb: self-checking bench for the pixel bounding box
// Streams frames of pixels through the block, predicts each frame's found
// flag and bounds in a scoreboard, and compares every response field by field.
// ----------------------------------------------------------------------------
module threshold_bounding_box_tb;
   import tbb_pkg::*;

   // Register index that decodes to nothing; writes to it must be dropped.
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;

   // Cycles to let the pipeline empty after the last response: intake stage,
   // two-entry queue, bound tracker and output register, plus margin.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_PIXELS  = 160;
   localparam int PHASE_FRAMES  = 13;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] left_col;
      logic [POS_BITS-1:0] top_row;
      logic [POS_BITS-1:0] right_col;
      logic [POS_BITS-1:0] bottom_row;
   } bbox_type;

   // Tracks the frame position and running bounds the block should hold, and
   // keeps the bounding boxes still owed by the block, oldest first.
   class bbox_scoreboard;
      logic [DIM_BITS-1:0]   width_reg  = WIDTH_RESET;
      logic [DIM_BITS-1:0]   height_reg = HEIGHT_RESET;
      logic [PIXEL_BITS-1:0] threshold  = THRESHOLD_RESET;
      logic [POS_BITS-1:0]   col, row, min_col, max_col, min_row, max_row;
      bit                    any_hit;
      bbox_type              boxes_due[$];
      int unsigned           pixels_taken, frames_closed, frames_checked, errors;

      function new();
         clear_frame();
      endfunction

      function void clear_frame();
         col     = '0;
         row     = '0;
         min_col = '0;
         max_col = '0;
         min_row = '0;
         max_row = '0;
         any_hit = 1'b0;
      endfunction

      // Size actually used by the counters: 0 acts as 1, big values saturate.
      function int unsigned span(logic [DIM_BITS-1:0] v);
         if (v == '0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function bit next_is_last();
         return (col + 32'd1 >= span(width_reg)) && (row + 32'd1 >= span(height_reg));
      endfunction

      function int unsigned pixels_left();
         int unsigned w, h, in_line;
         w = span(width_reg);
         h = span(height_reg);
         in_line = (col + 32'd1 >= w) ? 1 : w - col;
         if (row + 32'd1 >= h) return in_line;
         return in_line + (h - row - 1) * w;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DAT_BITS-1:0] value);
         case (idx)
            REG_FRAME_WIDTH:  width_reg  = value[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: height_reg = value[DIM_BITS-1:0];
            REG_THRESHOLD:    threshold  = value[PIXEL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIXEL_BITS-1:0] value);
         pixels_taken++;
         if (value > threshold) begin
            if (!any_hit) begin
               min_col = col;
               max_col = col;
               min_row = row;
               max_row = row;
               any_hit = 1'b1;
            end else begin
               if (col < min_col) min_col = col;
               if (col > max_col) max_col = col;
               if (row < min_row) min_row = row;
               if (row > max_row) max_row = row;
            end
         end
         // Compare with reach-or-pass so a size shrunk mid-frame ends the line.
         if (col + 32'd1 >= span(width_reg)) begin
            if (row + 32'd1 >= span(height_reg)) begin
               // Bounds stay zero when nothing counted, as the block reports.
               boxes_due.push_back({any_hit, min_col, min_row, max_col, max_row});
               frames_closed++;
               clear_frame();
            end else begin
               col = '0;
               row = row + 1'b1;
            end
         end else begin
            col = col + 1'b1;
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("[%0t] frame result %0d: %s", $time, frames_checked, what);
      endtask

      task check_box(bbox_type got);
         bbox_type want;
         frames_checked++;
         if (boxes_due.size() == 0) begin
            report_mismatch("response with no frame closed");
            return;
         end
         want = boxes_due.pop_front();
         if (got.found !== want.found)
            report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
         if (got.left_col !== want.left_col)
            report_mismatch($sformatf("left_col %0d, want %0d", got.left_col, want.left_col));
         if (got.top_row !== want.top_row)
            report_mismatch($sformatf("top_row %0d, want %0d", got.top_row, want.top_row));
         if (got.right_col !== want.right_col)
            report_mismatch($sformatf("right_col %0d, want %0d", got.right_col, want.right_col));
         if (got.bottom_row !== want.bottom_row)
            report_mismatch($sformatf("bottom_row %0d, want %0d",
                                      got.bottom_row, want.bottom_row));
      endtask
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [CSR_DAT_BITS-1:0] csr_data   = '0;
   logic                    req_valid  = 1'b0;
   logic                    req_ready;
   logic [PIXEL_BITS-1:0]   req_pixel  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready  = 1'b0;
   logic                    rsp_found;
   logic [POS_BITS-1:0]     rsp_left_col, rsp_top_row, rsp_right_col, rsp_bottom_row;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   bbox_scoreboard sb = new();

   threshold_bounding_box dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_left_col   (rsp_left_col),
      .rsp_top_row    (rsp_top_row),
      .rsp_right_col  (rsp_right_col),
      .rsp_bottom_row (rsp_bottom_row)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check each accepted response, then pick the next cycle's
   // ready at random. Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_box(bbox_type'({rsp_found, rsp_left_col, rsp_top_row,
                                     rsp_right_col, rsp_bottom_row}));
         rsp_ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
      end
   end

   // Hold one request until accepted. Valid stays high afterwards so that a
   // back-to-back request never lowers and raises it in the same step; drop
   // it only on a sender gap or in drain_frames.
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(value);
   endtask

   // Write one register; csr_valid stays high for a following write.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DAT_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // Program all three registers; optionally follow with a write to the
   // unused index, placed last so a decode bug cannot be overwritten.
   task automatic program_regs(input logic [CSR_DAT_BITS-1:0] width_word,
                               input logic [CSR_DAT_BITS-1:0] height_word,
                               input logic [CSR_DAT_BITS-1:0] thr_word,
                               input bit poke_unused);
      write_reg(REG_FRAME_WIDTH, width_word);
      write_reg(REG_FRAME_HEIGHT, height_word);
      write_reg(REG_THRESHOLD, thr_word);
      if (poke_unused) write_reg(REG_UNUSED, CSR_DAT_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait for every owed response, then let the pipeline empty:
   // a partial frame leaves pixels in flight that produce no response.
   task automatic drain_frames();
      req_valid <= 1'b0;
      while (sb.boxes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly at or below the threshold, some above, now and then an edge value.
   function automatic logic [PIXEL_BITS-1:0] pick_pixel(int hit_pct);
      int unsigned thr;
      thr = sb.threshold;
      if ($urandom_range(7, 0) == 0) begin
         case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            2:       return PIXEL_BITS'(thr);
            default: return (thr == 32'hFFFF) ? PIXEL_BITS'(thr) : PIXEL_BITS'(thr + 1);
         endcase
      end
      if ($urandom_range(99, 0) < hit_pct && thr < 32'hFFFF)
         return PIXEL_BITS'($urandom_range(32'hFFFF, thr + 1));
      return PIXEL_BITS'($urandom_range(thr, 0));
   endfunction

   // Small dimension in the low bits; junk in the bits above the register.
   function automatic logic [CSR_DAT_BITS-1:0] dim_word(int hi);
      logic [CSR_DAT_BITS-1:0] w;
      w = CSR_DAT_BITS'($urandom_range(hi, 0));
      w[CSR_DAT_BITS-1:DIM_BITS] = 3'($urandom);
      return w;
   endfunction

   function automatic logic [CSR_DAT_BITS-1:0] pick_threshold();
      case ($urandom_range(5, 0))
         0:       return '0;
         1:       return '1;
         default: return CSR_DAT_BITS'($urandom);
      endcase
   endfunction

   // Send pixels up to and including the one that closes the frame.
   task automatic send_frame(input int hit_pct, input bit force_last);
      bit last;
      last = 1'b0;
      while (!last) begin
         last = sb.next_is_last();
         send_pixel((last && force_last) ? '1 : pick_pixel(hit_pct));
      end
   endtask

   // One register setting with a few frames; sometimes resize mid-frame.
   task automatic run_setting();
      int frames, part, hit_pct;
      drain_frames();
      program_regs(dim_word(8), dim_word(6), pick_threshold(), $urandom_range(3, 0) == 0);
      frames  = $urandom_range(3, 1);
      hit_pct = $urandom_range(40, 2);
      repeat (frames) begin
         if ($urandom_range(4, 0) == 0 && sb.pixels_left() > 1) begin
            part = $urandom_range(sb.pixels_left() - 1, 1);
            repeat (part) send_pixel(pick_pixel(hit_pct));
            drain_frames();
            program_regs(dim_word(8), dim_word(6), pick_threshold(), 1'b0);
         end
         send_frame(hit_pct, 1'b0);
      end
   endtask

   initial begin
      int unsigned px_mark, fr_mark;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: 1920 wide, threshold 0, so a pixel of 1 counts. Shrink
      // to 2x1 mid-line; the next pixel passes the last column and closes.
      send_pixel(16'd0);
      send_pixel(16'd1);
      send_pixel(16'd0);
      drain_frames();
      program_regs(16'hE002, 16'h0001, 16'd100, 1'b0);
      send_pixel(16'd101);

      // 3x2 frame: a pixel equal to the threshold must not count.
      drain_frames();
      program_regs(16'd3, 16'd2, 16'd100, 1'b0);
      send_pixel(16'd100);
      send_pixel(16'd101);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      send_pixel(16'd100);
      send_pixel(16'd0);

      // Zero sizes act as 1x1; top threshold means nothing counts.
      drain_frames();
      program_regs(16'd0, 16'd0, 16'hFFFF, 1'b0);
      send_pixel(16'hFFFF);
      send_pixel(16'd0);

      // Threshold 0, then junk to the unused index: pixel 1 must still count.
      drain_frames();
      program_regs(16'd0, 16'd0, 16'd0, 1'b0);
      csr_valid <= 1'b1;
      write_reg(REG_UNUSED, 16'hFFFF);
      csr_valid <= 1'b0;
      send_pixel(16'd1);
      send_pixel(16'd0);

      // 4x3 frame cut down to 2x2 after a line and one pixel.
      drain_frames();
      program_regs(16'd4, 16'd3, 16'h7FFF, 1'b0);
      send_pixel(16'd0);
      send_pixel(16'd0);
      send_pixel(16'h8000);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      drain_frames();
      program_regs(16'd2, 16'd2, 16'h7FFF, 1'b0);
      send_frame(0, 1'b0);

      // Random part: busy receiver, then slow sender, then
      // full rate. Each phase runs until enough pixels and frames have gone.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct = 70;
            end
            1: begin
               req_idle_pct = 70;
               rsp_idle_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         px_mark = sb.pixels_taken;
         fr_mark = sb.frames_closed;
         while (sb.pixels_taken - px_mark < PHASE_PIXELS ||
                sb.frames_closed - fr_mark < PHASE_FRAMES)
            run_setting();
      end

      // Oversized sizes saturate to a full-size frame, so a few pixels must
      // not close a line; shrink to 2x1 and the next pixel closes the frame.
      drain_frames();
      program_regs(16'h1FFF, 16'h1FFF, 16'h8000, 1'b0);
      send_pixel(16'd0);
      send_pixel(16'hFFFF);
      send_pixel(16'd0);
      send_pixel(16'h8001);
      send_pixel(16'h8000);
      drain_frames();
      program_regs(16'd2, 16'd1, 16'h8000, 1'b0);
      send_pixel(16'hFFFF);

      drain_frames();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("timeout with %0d frame results outstanding", sb.boxes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
design/tbb_pkg.sv
design/tbb_front.sv
design/tbb_queue.sv
design/tbb_back.sv
design/threshold_bounding_box.sv
tb/threshold_bounding_box_tb.sv
